// ===== hw/rtl/brms_pkg.sv =====
package brms_pkg;

  // Fixed widths of the accumulators, the window register and the results.
  localparam int SUM_W  = 42;
  localparam int WIN_W  = 13;
  localparam int RMS_W  = 16;
  localparam int ROOT_W = SUM_W / 2;

  // Window lengths above this are clamped; zero is treated as one.
  localparam int MAX_WINDOW   = 4096;
  localparam int WINDOW_RESET = 256;

  // Register index decoded from paddr[2].
  localparam logic [0:0] REG_WINDOW = 1'b0;

  // Control from the sequencer to each square accumulator.
  typedef struct packed {
    logic start;
    logic clr;
  } acc_ctl_t;

endpackage

// ===== hw/rtl/brms_sq_acc.sv =====
module brms_sq_acc #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  brms_pkg::acc_ctl_t          ctl,
  input  logic [SAMPLE_BITS-1:0]      sample,
  output logic                        done,
  output logic [brms_pkg::SUM_W-1:0]  sum
);

  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
  localparam int ADD_W = ((SQ_W > brms_pkg::SUM_W) ? SQ_W : brms_pkg::SUM_W) + 1;
  localparam logic [ADD_W-1:0] SUM_MAX = ADD_W'({brms_pkg::SUM_W{1'b1}});

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] mcand;
  logic [SQ_W-1:0]        prod;
  logic [SQ_W-1:0]        prod_next;
  logic [SAMPLE_BITS:0]   hi_sum;
  logic [CNT_W-1:0]       bit_cnt;
  logic                   mul_busy;
  logic                   add_pend;
  logic [ADD_W-1:0]       sum_ext;

  // Magnitude of a two's complement sample; the most negative value maps to
  // 2^(SAMPLE_BITS-1), which still fits unsigned.
  assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  // Shift-add multiplier: one multiplier bit is retired per cycle.
  assign hi_sum    = {1'b0, prod[SQ_W-1:SAMPLE_BITS]}
                   + {1'b0, (prod[0] ? mcand : {SAMPLE_BITS{1'b0}})};
  assign prod_next = {hi_sum, prod[SAMPLE_BITS-1:1]};

  assign sum_ext = ADD_W'(sum) + ADD_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      add_pend <= 1'b0;
      done     <= 1'b0;
      sum      <= '0;
      bit_cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.clr) begin
        sum <= '0;
      end
      if (ctl.start) begin
        mul_busy <= 1'b1;
        bit_cnt  <= '0;
      end else if (mul_busy) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == CNT_W'(SAMPLE_BITS - 1)) begin
          mul_busy <= 1'b0;
          add_pend <= 1'b1;
        end
      end else if (add_pend) begin
        // Saturating accumulate of the finished square.
        sum      <= (sum_ext > SUM_MAX) ? SUM_MAX[brms_pkg::SUM_W-1:0]
                                        : sum_ext[brms_pkg::SUM_W-1:0];
        add_pend <= 1'b0;
        done     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod  <= {{SAMPLE_BITS{1'b0}}, mag};
      mcand <= mag;
    end else if (mul_busy) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== hw/rtl/brms_div.sv =====
module brms_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [brms_pkg::SUM_W-1:0]  dividend,
  input  logic [brms_pkg::WIN_W-1:0]  divisor,
  output logic                        done,
  output logic [brms_pkg::SUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(brms_pkg::SUM_W + 1);

  logic [brms_pkg::WIN_W-1:0] div_q;
  logic [brms_pkg::WIN_W-1:0] rem_q;
  logic [brms_pkg::WIN_W:0]   trial;
  logic [brms_pkg::WIN_W:0]   diff;
  logic                       ge;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;

  // Restoring division: the dividend shifts out of the top of the quotient
  // register while quotient bits shift in at the bottom.
  assign trial = {rem_q, quotient[brms_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(brms_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      div_q    <= divisor;
      rem_q    <= '0;
    end else if (busy) begin
      quotient <= {quotient[brms_pkg::SUM_W-2:0], ge};
      rem_q    <= ge ? diff[brms_pkg::WIN_W-1:0] : trial[brms_pkg::WIN_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/brms_isqrt.sv =====
module brms_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [brms_pkg::SUM_W-1:0]   radicand,
  output logic                         done,
  output logic [brms_pkg::ROOT_W-1:0]  root
);

  localparam int REM_W = brms_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(brms_pkg::ROOT_W + 1);

  logic [brms_pkg::SUM_W-1:0] rad;
  logic [REM_W-1:0]           rem_q;
  logic [REM_W-1:0]           trial;
  logic [REM_W-1:0]           test;
  logic                       ge;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;

  // Digit-by-digit square root: two radicand bits enter per cycle and one
  // root bit is decided. Before each step the partial remainder is no wider
  // than the root field, so its two top bits can be dropped.
  assign trial = {rem_q[REM_W-3:0], rad[brms_pkg::SUM_W-1 -: 2]};
  assign test  = {root, 2'b01};
  assign ge    = (trial >= test);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(brms_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      rem_q <= '0;
      root  <= '0;
    end else if (busy) begin
      rad   <= {rad[brms_pkg::SUM_W-3:0], 2'b00};
      rem_q <= ge ? (trial - test) : trial;
      root  <= {root[brms_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/block_rms_meter_two_channel_unit.sv =====
// Two-channel block RMS meter.
// Input stream: s_axis_tdata carries a voltage and a current sample, s_axis_tuser
// carries the valid and clear flags. Every accepted word returns exactly one output
// word with the current voltage and current RMS pair and an update flag.
// A valid word adds both squares to the running sums; when the count reaches the
// window length, each RMS becomes floor(sqrt(sum / window)) and the sums restart.
// A word with clear set or valid low zeroes the sums, the count and both RMS values.
// One word is processed at a time. The squares come from a bit-serial shift-add
// multiplier and are added to the sums; a word that does not close a window then
// goes to the output stage, and the next word is taken once its output word has
// been registered. A word that closes a window also runs a restoring divider and a
// two-bit-per-step square root before its output stage. A cleared word goes
// straight to the output stage.
// The window length register sits at APB address 0 and resets to 256; it is to be
// written only while the meter is idle. Reset also zeroes sums, count and RMS values.
// If the output is stalled, the finished word holds in the output register; the next
// input word is still taken and computed, and input then stops until the held word
// has been delivered.
module block_rms_meter_two_channel_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: voltage sample, current sample, zero fill to a whole byte
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser from bit 0: sample_valid, clear
  input  logic [1:0]                         s_axis_tuser,
  // Output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: vout_rms, iout_rms
  output logic [2*brms_pkg::RMS_W-1:0]       m_axis_tdata,
  // tuser from bit 0: rms_updated
  output logic [0:0]                         m_axis_tuser
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  localparam int WIN_W = brms_pkg::WIN_W;
  localparam int RMS_W = brms_pkg::RMS_W;
  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(brms_pkg::MAX_WINDOW);

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [WIN_W-1:0]            window_length;
  logic [WIN_W-1:0]            win_eff;
  logic [WIN_W-1:0]            count;
  logic [WIN_W-1:0]            count_inc;
  logic                        win_hit;
  logic [RMS_W-1:0]            vout_rms;
  logic [RMS_W-1:0]            iout_rms;
  logic                        upd_flag;
  logic                        in_fire;
  logic                        in_good;
  logic                        out_free;
  logic                        cfg_wr;

  brms_pkg::acc_ctl_t          acc_ctl;
  logic                        v_sq_done;
  logic                        i_sq_done;
  logic [brms_pkg::SUM_W-1:0]  v_sum;
  logic [brms_pkg::SUM_W-1:0]  i_sum;
  logic                        div_start;
  logic                        v_div_done;
  logic                        i_div_done;
  logic [brms_pkg::SUM_W-1:0]  v_quot;
  logic [brms_pkg::SUM_W-1:0]  i_quot;
  logic                        rt_start;
  logic                        v_rt_done;
  logic                        i_rt_done;
  logic [brms_pkg::ROOT_W-1:0] v_root;
  logic [brms_pkg::ROOT_W-1:0] i_root;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == brms_pkg::REG_WINDOW);
  assign prdata = (paddr[2:2] == brms_pkg::REG_WINDOW) ? 32'(window_length) : 32'd0;

  assign win_eff = (window_length == '0)    ? WIN_W'(1) :
                   (window_length > WIN_MAX) ? WIN_MAX : window_length;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_good       = s_axis_tuser[0] && !s_axis_tuser[1];
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign count_inc = count + 1'b1;
  assign win_hit   = (count_inc >= win_eff);

  // The divider captures the sums on the same edge that clears them.
  assign div_start     = (state == ST_SQ) && v_sq_done && win_hit;
  assign rt_start      = (state == ST_DIV) && v_div_done;
  assign acc_ctl.start = in_fire && in_good;
  assign acc_ctl.clr   = (in_fire && !in_good) || div_start;

  brms_sq_acc #(.SAMPLE_BITS(SAMPLE_BITS)) u_v_acc (
    .clk(clk), .rst(rst), .ctl(acc_ctl),
    .sample(s_axis_tdata[SAMPLE_BITS-1:0]),
    .done(v_sq_done), .sum(v_sum)
  );

  brms_sq_acc #(.SAMPLE_BITS(SAMPLE_BITS)) u_i_acc (
    .clk(clk), .rst(rst), .ctl(acc_ctl),
    .sample(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .done(i_sq_done), .sum(i_sum)
  );

  brms_div u_v_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(v_sum), .divisor(win_eff),
    .done(v_div_done), .quotient(v_quot)
  );

  brms_div u_i_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(i_sum), .divisor(win_eff),
    .done(i_div_done), .quotient(i_quot)
  );

  brms_isqrt u_v_rt (
    .clk(clk), .rst(rst), .start(rt_start), .radicand(v_quot),
    .done(v_rt_done), .root(v_root)
  );

  brms_isqrt u_i_rt (
    .clk(clk), .rst(rst), .start(rt_start), .radicand(i_quot),
    .done(i_rt_done), .root(i_root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = in_good ? ST_SQ : ST_PUSH;
      end
      ST_SQ: begin
        if (v_sq_done) state_next = win_hit ? ST_DIV : ST_PUSH;
      end
      ST_DIV: begin
        if (v_div_done) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (v_rt_done) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= WIN_W'(brms_pkg::WINDOW_RESET);
      count         <= '0;
      vout_rms      <= '0;
      iout_rms      <= '0;
      upd_flag      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        window_length <= pwdata[WIN_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_fire) begin
        upd_flag <= 1'b0;
        if (!in_good) begin
          count    <= '0;
          vout_rms <= '0;
          iout_rms <= '0;
        end
      end
      if (state == ST_SQ && v_sq_done) begin
        count <= win_hit ? '0 : count_inc;
      end
      if (state == ST_SQRT && v_rt_done) begin
        // Roots above the result width saturate.
        vout_rms <= (v_root[brms_pkg::ROOT_W-1:RMS_W] != '0) ? {RMS_W{1'b1}}
                                                             : v_root[RMS_W-1:0];
        iout_rms <= (i_root[brms_pkg::ROOT_W-1:RMS_W] != '0) ? {RMS_W{1'b1}}
                                                             : i_root[RMS_W-1:0];
        upd_flag <= 1'b1;
      end
      if (state == ST_PUSH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && out_free) begin
      m_axis_tdata <= {iout_rms, vout_rms};
      m_axis_tuser <= upd_flag;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < WIN_MAX)
    else $error("window count reached the clamp limit");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_good) |=> (count == '0 && vout_rms == '0 && iout_rms == '0 && !upd_flag))
    else $error("cleared word left state behind");

  a_acc_lockstep: assert property (@(posedge clk) disable iff (rst)
    (v_sq_done == i_sq_done) && (v_div_done == i_div_done) && (v_rt_done == i_rt_done))
    else $error("channel units out of step");

  a_update_only_from_root: assert property (@(posedge clk) disable iff (rst)
    $rose(upd_flag) |-> $past(state == ST_SQRT && v_rt_done))
    else $error("update flag set outside a window close");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic [15:0] vout;
    logic [15:0] iout;
    logic        valid;
    logic        clr;
  } sample_word_t;

  typedef struct packed {
    logic [15:0] vout_rms;
    logic [15:0] iout_rms;
    logic        updated;
  } rms_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  block_rms_meter_two_channel_unit dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  sample_word_t pending_samples[$];
  rms_word_t    expected_rms[$];
  sample_word_t word_on_bus;
  int           mismatch_count = 0;
  int           in_gap = 0;
  int           out_stall = 0;
  int           idle_cycles = 0;
  bit           no_idling = 1'b0;

  // Shadow of the meter state.
  logic [41:0] v_square_sum, i_square_sum;
  logic [12:0] window_count, window_reg;
  logic [15:0] v_rms_now, i_rms_now;

  function automatic logic [33:0] square_mag(logic [15:0] s);
    logic [16:0] mag;
    logic [33:0] m;
    mag = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    m = mag;
    return m * m;
  endfunction

  function automatic logic [41:0] sat_add(logic [41:0] a, logic [33:0] b);
    logic [42:0] s;
    s = {1'b0, a} + {9'b0, b};
    return s[42] ? {42{1'b1}} : s[41:0];
  endfunction

  function automatic logic [15:0] rms_from_sum(logic [41:0] sum, logic [12:0] win);
    logic [63:0] x, root, probe;
    x = 64'(sum) / 64'(win);
    root = '0;
    probe = 64'h1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= root + probe) begin
        x = x - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
  endfunction

  task automatic predict_rms_word(input sample_word_t w);
    logic [12:0] eff;
    rms_word_t r;
    r.updated = 1'b0;
    if (w.clr || !w.valid) begin
      v_square_sum = '0;
      i_square_sum = '0;
      window_count = '0;
      v_rms_now = '0;
      i_rms_now = '0;
    end else begin
      if (window_reg == 0) eff = 13'd1;
      else if (window_reg > brms_pkg::MAX_WINDOW) eff = 13'(brms_pkg::MAX_WINDOW);
      else eff = window_reg;
      v_square_sum = sat_add(v_square_sum, square_mag(w.vout));
      i_square_sum = sat_add(i_square_sum, square_mag(w.iout));
      window_count = window_count + 1;
      if (window_count >= eff) begin
        v_rms_now = rms_from_sum(v_square_sum, eff);
        i_rms_now = rms_from_sum(i_square_sum, eff);
        v_square_sum = '0;
        i_square_sum = '0;
        window_count = '0;
        r.updated = 1'b1;
      end
    end
    r.vout_rms = v_rms_now;
    r.iout_rms = i_rms_now;
    expected_rms.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sender: one word on the bus at a time, with random gaps between words.
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      in_gap = 0;
      v_square_sum = '0;
      i_square_sum = '0;
      window_count = '0;
      v_rms_now = '0;
      i_rms_now = '0;
      window_reg = 13'(brms_pkg::WINDOW_RESET);
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_rms_word(word_on_bus);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_samples.size() > 0) begin
          word_on_bus = pending_samples.pop_front();
          s_axis_tdata <= {word_on_bus.iout, word_on_bus.vout};
          s_axis_tuser <= {word_on_bus.clr, word_on_bus.valid};
          next_valid = 1'b1;
          if (!no_idling && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 11);
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Receiver: random stall bursts, and the check of each delivered word.
  always @(posedge clk) begin
    rms_word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rms.size() == 0) begin
          report_mismatch($sformatf("output word %h/%b with nothing expected",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = expected_rms.pop_front();
          if (m_axis_tdata[15:0] != want.vout_rms)
            report_mismatch($sformatf("vout_rms %0d, expected %0d",
                                      m_axis_tdata[15:0], want.vout_rms));
          if (m_axis_tdata[31:16] != want.iout_rms)
            report_mismatch($sformatf("iout_rms %0d, expected %0d",
                                      m_axis_tdata[31:16], want.iout_rms));
          if (m_axis_tuser[0] != want.updated)
            report_mismatch($sformatf("rms_updated %b, expected %b",
                                      m_axis_tuser[0], want.updated));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idling && $urandom_range(0, 15) == 0) out_stall = $urandom_range(1, 11);
      end
    end
  end

  // Watchdog on cycles in which no word and no register write moves.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_window_length(input logic [12:0] len);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {brms_pkg::REG_WINDOW, 2'b00};
    pwdata <= {19'b0, len};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    window_reg = len;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_rms.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_sample(input logic [15:0] v, input logic [15:0] i,
                              input logic valid, input logic clr);
    sample_word_t w;
    w.vout = v;
    w.iout = i;
    w.valid = valid;
    w.clr = clr;
    pending_samples.push_back(w);
  endtask

  function automatic logic [15:0] pick_sample_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly valid samples; now and then an invalid or cleared word.
  task automatic queue_random_word();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick == 0) queue_sample(pick_sample_value(), pick_sample_value(), 1'b0, 1'b0);
    else if (pick == 1)
      queue_sample(pick_sample_value(), pick_sample_value(), 1'($urandom), 1'b1);
    else queue_sample(pick_sample_value(), pick_sample_value(), 1'b1, 1'b0);
  endtask

  initial begin
    int sent, n, win;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset window of 256: extremes, invalid and cleared words, then 260 random words.
    queue_sample(16'h8000, 16'h7FFF, 1'b1, 1'b0);
    queue_sample(16'h7FFF, 16'h8000, 1'b1, 1'b0);
    queue_sample(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    queue_sample(16'h1234, 16'h4321, 1'b0, 1'b0);
    queue_sample(16'h8000, 16'h8000, 1'b1, 1'b1);
    queue_sample(16'h8000, 16'h8000, 1'b0, 1'b1);
    for (int k = 0; k < 260; k++) queue_random_word();
    sent = 260;
    wait_drained();

    // Zero window acts as one: every valid sample closes a window.
    write_window_length(13'd0);
    queue_sample(16'h8000, 16'h8000, 1'b1, 1'b0);
    queue_sample(16'h7FFF, 16'h0001, 1'b1, 1'b0);
    queue_sample(16'hFFFF, 16'h0000, 1'b1, 1'b0);
    // Clear wins over a valid sample.
    queue_sample(16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    queue_sample(16'h4000, 16'hC000, 1'b1, 1'b0);
    queue_sample(16'h4000, 16'hC000, 1'b0, 1'b0);
    wait_drained();

    write_window_length(13'd1);
    queue_sample(16'h8001, 16'h00FF, 1'b1, 1'b0);
    queue_sample(16'h0000, 16'h0000, 1'b1, 1'b0);
    wait_drained();

    // Window shortened while a partial window is open.
    write_window_length(13'd8);
    for (int k = 0; k < 5; k++) queue_sample(16'h7000, 16'h9000, 1'b1, 1'b0);
    wait_drained();
    write_window_length(13'd3);
    queue_sample(16'h0100, 16'hFF00, 1'b1, 1'b0);
    queue_sample(16'h0300, 16'h0001, 1'b1, 1'b0);
    wait_drained();

    // Oversized window is clamped, so a short run of full-scale samples stays open.
    write_window_length(13'h1FFF);
    for (int k = 0; k < 40; k++) queue_sample(16'h8000, 16'h8000, 1'b1, 1'b0);
    wait_drained();

    write_window_length(13'(brms_pkg::MAX_WINDOW));
    for (int k = 0; k < 40; k++) queue_random_word();
    queue_sample(16'h0000, 16'h0000, 1'b1, 1'b1);
    wait_drained();

    // Random phases, each with its own window length.
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(0, 19);
      if (n < 14) win = $urandom_range(1, 16);
      else if (n < 19) win = $urandom_range(17, 300);
      else win = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(4097, 8191);
      write_window_length(13'(win));
      if (win == 0 || win > 300) n = $urandom_range(5, 40);
      else if (win > 16) n = win + $urandom_range(0, 8);
      else n = win * $urandom_range(1, 4) + $urandom_range(0, win - 1);
      if (RANDOM_ITEMS - sent < 120) no_idling = 1'b1;
      for (int k = 0; k < n; k++) queue_random_word();
      sent += n;
      wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (expected_rms.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_rms.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/brms_pkg.sv
hw/rtl/brms_sq_acc.sv
hw/rtl/brms_div.sv
hw/rtl/brms_isqrt.sv
hw/rtl/block_rms_meter_two_channel_unit.sv
tb/sv/tb.sv
